>>> sv/step_division_audio_looper_top_macros.svh
// assertion macros shared by the looper checks
// clocked on clk, disabled while arst_n is low
`ifndef STEP_DIVISION_AUDIO_LOOPER_TOP_MACROS_SVH
`define STEP_DIVISION_AUDIO_LOOPER_TOP_MACROS_SVH

// same-cycle implication
`define SDAL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("looper check failed");

// next-cycle implication
`define SDAL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("looper check failed");

`endif

>>> sv/sdal_pkg.sv
// types and constants of the step division audio looper
// no dependencies
`default_nettype none

package sdal_pkg;

	localparam int SAMPLE_BITS  = 24;
	localparam int MAX_LOOP_DEF = 4194304;
	localparam int TGT_W        = 23;
	localparam int CUT_W        = 15;
	localparam int DEL_W        = 11;
	localparam int FB_W         = 7;
	localparam int STEP_W       = 3;
	localparam int CFG_IDX_W    = 3;
	localparam int TGT_RESET    = 96000;

	localparam logic [1:0] MODE_EMPTY = 2'd0;
	localparam logic [1:0] MODE_PLAY  = 2'd1;
	localparam logic [1:0] MODE_DUB   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REC_CUT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REC_DEL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REC_FB  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REC_STP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET  = 3'd5;

	typedef struct packed {
		logic [1:0]                    mode;
		logic signed [SAMPLE_BITS-1:0] left_in;
		logic signed [SAMPLE_BITS-1:0] right_in;
		logic [CUT_W-1:0]              knob_cutoff;
		logic [DEL_W-1:0]              knob_delay;
		logic [FB_W-1:0]               knob_feedback;
		logic [STEP_W-1:0]             knob_step;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_out;
		logic signed [SAMPLE_BITS-1:0] right_out;
		logic [CUT_W-1:0]              active_cutoff;
		logic [DEL_W-1:0]              active_delay;
		logic [FB_W-1:0]               active_feedback;
	} result_t;

	// one entry of the loop memory: audio plus the four automation lanes
	typedef struct packed {
		logic [STEP_W-1:0]             step;
		logic [FB_W-1:0]               fb;
		logic [DEL_W-1:0]              del;
		logic [CUT_W-1:0]              cut;
		logic signed [SAMPLE_BITS-1:0] r;
		logic signed [SAMPLE_BITS-1:0] l;
	} lane_word_t;

endpackage

`default_nettype wire

>>> sv/sdal_ram.sv
// generic single-port ram with registered read
// no dependencies
`default_nettype none

module sdal_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

>>> sv/sdal_div.sv
// iterative restoring divider giving the remainder, one bit per cycle
// no dependencies
`default_nettype none

module sdal_div #(
	parameter int W = 34
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic      [W-1:0] remainder
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q, quo_q, den_q;
	logic [CW-1:0] cnt_q;
	logic          run_q, done_q;
	logic [W:0]    trial;
	logic          ge;

	assign trial = {rem_q, quo_q[W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? W'(trial - {1'b0, den_q}) : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

>>> sv/step_division_audio_looper_top.sv
// Stereo looper with overdub, step division and automation lanes. Audio and
// the four lanes share one single-port memory of MAX_LOOP entries, read and
// written back one entry per item; no clearing pass, mode empty only resets
// positions and length. Mode empty, play with nothing recorded, the unused
// mode and a first-pass recording item go straight to their result; the
// one that ends the pass first derives the one-third length by a reciprocal
// multiply. A played or overdubbed item reads its step code (skipped while
// the step knob is recorded), then runs the bit-serial divider that folds
// the read position into the active section, writes back on overdub and
// gives its result. A result still waiting at the output holds the next one
// in its last step.
// depends on sdal_pkg, sdal_ram, sdal_div
`default_nettype none

module step_division_audio_looper_top
	import sdal_pkg::*;
#(
	parameter int MAX_LOOP = MAX_LOOP_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_ready,
	input  wire item_t                item,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output result_t                   result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [TGT_W-1:0]     cfg_wdata
);

	localparam int ADDR_W = $clog2(MAX_LOOP);
	localparam int LEN_W  = $clog2(MAX_LOOP + 1);
	localparam int MUL_W  = LEN_W + 9;
	localparam int DIV_W  = LEN_W;
	localparam int CMP_W  = (LEN_W > TGT_W) ? LEN_W : TGT_W;
	localparam int WORD_W = $bits(lane_word_t);
	// x / 1000 as (x * RECIP_1000) >> RECIP_SH, exact for any 32-bit x
	localparam logic [31:0] RECIP_1000 = 32'd274877907;
	localparam int          RECIP_SH   = 38;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_STEP = 4'd1;
	localparam logic [3:0] S_CODE = 4'd2;
	localparam logic [3:0] S_MOD  = 4'd3;
	localparam logic [3:0] S_WB   = 4'd4;
	localparam logic [3:0] S_MUL  = 4'd5;
	localparam logic [3:0] S_D3GO = 4'd6;
	localparam logic [3:0] S_D3   = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;

	logic [3:0] state_q;

	logic             rev_q, rcut_q, rdel_q, rfb_q, rstp_q;
	logic [TGT_W-1:0] target_q;

	logic [LEN_W-1:0]  wpos_q, rpos_q, len_q, len3_q, act_q, rp_q;
	logic [ADDR_W-1:0] p_q;
	logic [STEP_W-1:0] code_q;
	logic [31:0]       prod_q;
	logic [63:0]       scl_q;
	item_t             item_q;
	result_t           wres_q, res_q;
	logic              res_valid_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	lane_word_t        ram_wdata, ram_rdata;
	logic [WORD_W-1:0] ram_rbits;

	logic             div_start, div_done;
	logic [DIV_W-1:0] div_a, div_b, div_rem;

	logic [CMP_W-1:0]  tgt_ext;
	logic [LEN_W-1:0]  tgt_eff, wpos_nx, q_pos, act_c, rp_c, p_c;
	logic [STEP_W-1:0] code_c;
	logic              accept;
	logic              fin_go;
	lane_word_t        wb_word;

	function automatic logic [LEN_W-1:0] div_len(input logic [LEN_W-1:0] len,
		input logic [LEN_W-1:0] len3, input logic [STEP_W-1:0] code);
		logic [LEN_W+1:0] l3;
		logic [LEN_W-1:0] a;
		l3 = {2'b00, len} + {1'b0, len, 1'b0};
		case (code)
			3'd1: a = l3[LEN_W+1:2];
			3'd2: a = len >> 1;
			3'd3: a = len3;
			3'd4: a = len >> 2;
			3'd5: a = len >> 3;
			3'd6: a = len >> 4;
			3'd7: a = len >> 5;
			default: a = len;
		endcase
		if (a == '0) begin
			a = len;
		end
		return a;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat_add(
		input logic signed [SAMPLE_BITS-1:0] a, input logic signed [SAMPLE_BITS-1:0] b);
		logic signed [SAMPLE_BITS:0] s;
		s = {a[SAMPLE_BITS-1], a} + {b[SAMPLE_BITS-1], b};
		if (s[SAMPLE_BITS] != s[SAMPLE_BITS-1]) begin
			return s[SAMPLE_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
				: {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
		return s[SAMPLE_BITS-1:0];
	endfunction

	sdal_ram #(.WIDTH(WORD_W), .DEPTH(MAX_LOOP)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rbits)
	);
	assign ram_rdata = lane_word_t'(ram_rbits);

	sdal_div #(.W(DIV_W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_a),
		.divisor   (div_b),
		.done      (div_done),
		.remainder (div_rem)
	);

	assign item_ready   = (state_q == S_IDLE);
	assign accept       = item_valid && item_ready;
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign fin_go       = (state_q == S_FIN) && (!res_valid_q || result_ready);

	// target in effect, limited to 1..MAX_LOOP
	assign tgt_ext = CMP_W'(target_q);
	always_comb begin
		if (tgt_ext == '0) begin
			tgt_eff = LEN_W'(1);
		end else if (tgt_ext > CMP_W'(MAX_LOOP)) begin
			tgt_eff = LEN_W'(MAX_LOOP);
		end else begin
			tgt_eff = LEN_W'(tgt_ext);
		end
	end

	assign wpos_nx = wpos_q + LEN_W'(1);
	// read position never exceeds the recorded length, so the fold is one compare
	assign q_pos   = (rpos_q == len_q) ? '0 : rpos_q;
	assign code_c  = (state_q == S_STEP) ? ram_rdata.step : code_q;
	assign act_c   = div_len(len_q, len3_q, code_q);
	assign rp_c    = div_rem[LEN_W-1:0];
	assign p_c     = rev_q ? (act_q - LEN_W'(1) - rp_c) : rp_c;

	always_comb begin
		wb_word = ram_rdata;
		if (item_q.mode == MODE_DUB) begin
			wb_word.l = sat_add(ram_rdata.l, item_q.left_in);
			wb_word.r = sat_add(ram_rdata.r, item_q.right_in);
			if (rcut_q) wb_word.cut = item_q.knob_cutoff;
			if (rdel_q) wb_word.del = item_q.knob_delay;
			if (rfb_q)  wb_word.fb  = item_q.knob_feedback;
			if (rstp_q) wb_word.step = item_q.knob_step;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = p_q;
		ram_wdata = wb_word;
		div_start = 1'b0;
		div_a     = DIV_W'(rpos_q);
		div_b     = DIV_W'(act_c);
		case (state_q)
			S_IDLE: begin
				if (item.mode == MODE_DUB && len_q == '0) begin
					ram_we    = accept;
					ram_addr  = wpos_q[ADDR_W-1:0];
					ram_wdata = '{step: item.knob_step, fb: item.knob_feedback,
						del: item.knob_delay, cut: item.knob_cutoff,
						r: item.right_in, l: item.left_in};
				end else begin
					ram_addr = q_pos[ADDR_W-1:0];
				end
			end
			S_CODE: div_start = 1'b1;
			S_MOD:  ram_addr = p_c[ADDR_W-1:0];
			S_WB:   ram_we = (item_q.mode == MODE_DUB);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_q    <= 1'b0;
			rcut_q   <= 1'b0;
			rdel_q   <= 1'b0;
			rfb_q    <= 1'b0;
			rstp_q   <= 1'b0;
			target_q <= TGT_W'(TGT_RESET);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_REVERSE: rev_q    <= cfg_wdata[0];
				CFG_REC_CUT: rcut_q   <= cfg_wdata[0];
				CFG_REC_DEL: rdel_q   <= cfg_wdata[0];
				CFG_REC_FB:  rfb_q    <= cfg_wdata[0];
				CFG_REC_STP: rstp_q   <= cfg_wdata[0];
				CFG_TARGET:  target_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fin_go) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wpos_q  <= '0;
			rpos_q  <= '0;
			len_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_FIN;
						if (item.mode == MODE_EMPTY) begin
							wpos_q <= '0;
							rpos_q <= '0;
							len_q  <= '0;
						end else if (item.mode == MODE_DUB && len_q == '0) begin
							if (wpos_nx >= tgt_eff) begin
								len_q   <= tgt_eff;
								rpos_q  <= '0;
								wpos_q  <= '0;
								state_q <= S_MUL;
							end else begin
								wpos_q <= wpos_nx;
							end
						end else if ((item.mode == MODE_PLAY || item.mode == MODE_DUB)
							&& len_q != '0) begin
							state_q <= rstp_q ? S_CODE : S_STEP;
						end
					end
				end
				S_STEP: state_q <= S_CODE;
				S_CODE: state_q <= S_MOD;
				S_MOD:  if (div_done) state_q <= S_WB;
				S_WB: begin
					rpos_q  <= rp_q + LEN_W'(1);
					state_q <= S_FIN;
				end
				S_MUL:  state_q <= S_D3GO;
				S_D3GO: state_q <= S_D3;
				S_D3:   state_q <= S_FIN;
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			code_q <= item.knob_step;
			wres_q <= '{left_out: item.left_in, right_out: item.right_in,
				active_cutoff: item.knob_cutoff, active_delay: item.knob_delay,
				active_feedback: item.knob_feedback};
		end
		if (state_q == S_STEP) begin
			code_q <= code_c;
		end
		if (state_q == S_CODE) begin
			act_q <= act_c;
		end
		if (state_q == S_MOD && div_done) begin
			rp_q <= rp_c;
			p_q  <= p_c[ADDR_W-1:0];
		end
		if (state_q == S_WB) begin
			wres_q.left_out  <= wb_word.l;
			wres_q.right_out <= wb_word.r;
			if (!rcut_q) wres_q.active_cutoff   <= ram_rdata.cut;
			if (!rdel_q) wres_q.active_delay    <= ram_rdata.del;
			if (!rfb_q)  wres_q.active_feedback <= ram_rdata.fb;
		end
		if (state_q == S_MUL) begin
			prod_q <= 32'(MUL_W'(len_q) * MUL_W'(333));
		end
		// one-third length: len*333/1000 through the reciprocal of 1000
		if (state_q == S_D3GO) begin
			scl_q <= {32'd0, prod_q} * {32'd0, RECIP_1000};
		end
		if (state_q == S_D3) begin
			len3_q <= LEN_W'(scl_q >> RECIP_SH);
		end
		if (fin_go) begin
			res_q <= wres_q;
		end
	end

endmodule

`default_nettype wire

>>> sv/sdal_chk.sv
// port-level checks of the looper top, attached by bind
// depends on sdal_pkg and the assertion macro header
`default_nettype none
`include "step_division_audio_looper_top_macros.svh"

module sdal_chk
	import sdal_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    item_valid,
	input wire logic    item_ready,
	input wire logic    result_valid,
	input wire logic    result_ready,
	input wire result_t result
);

	// a stalled result holds
	`SDAL_ASSERT_NEXT(a_res_hold, result_valid && !result_ready, result_valid && $stable(result))
	// one item at a time: busy after each transfer
	`SDAL_ASSERT_NEXT(a_busy_after, item_valid && item_ready, !item_ready)
	// a new result only follows a busy cycle
	`SDAL_ASSERT_NOW(a_res_after_work, $rose(result_valid), $past(!item_ready))

endmodule

bind step_division_audio_looper_top sdal_chk u_sdal_chk (.*);

`default_nettype wire

>>> bench/tb_top.sv
// testbench for the step division audio looper: directed and random stimulus
// checked against a behavioral predictor of loop store, lanes and positions
// depends on sdal_pkg and step_division_audio_looper_top
`default_nettype none

module tb_top;
	import sdal_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 80;
	localparam int unsigned POS_MASK = 32'h7FFFFF;
	localparam int SMP_MAX = 8388607;
	localparam int SMP_MIN = -8388608;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	item_t item;
	logic result_valid;
	logic result_ready;
	result_t result;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [TGT_W-1:0] cfg_wdata;

	step_division_audio_looper_top DUT (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	// predictor state
	logic signed [SAMPLE_BITS-1:0] loop_l[int];
	logic signed [SAMPLE_BITS-1:0] loop_r[int];
	logic [CUT_W-1:0]  cut_lane[int];
	logic [DEL_W-1:0]  del_lane[int];
	logic [FB_W-1:0]   fb_lane[int];
	logic [STEP_W-1:0] step_lane[int];
	int unsigned wr_pos, rd_pos, loop_len;
	bit reverse_on, rec_cut, rec_del, rec_fb, rec_step;
	int unsigned target_len;

	result_t expected_q[$];
	int errors;
	int send_idle_pct, recv_idle_pct;
	bit hold_req;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		item_valid = 0;
		item = '0;
		cfg_we = 0;
		cfg_idx = '0;
		cfg_wdata = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	function automatic int unsigned section_len(int unsigned len, logic [STEP_W-1:0] code);
		longint unsigned l, a;
		l = len;
		case (code)
			3'd1: a = (l * 3) >> 2;
			3'd2: a = l >> 1;
			3'd3: a = (l * 333) / 1000;
			3'd4: a = l >> 2;
			3'd5: a = l >> 3;
			3'd6: a = l >> 4;
			3'd7: a = l >> 5;
			default: a = l;
		endcase
		if (a < 1) a = l;
		return int'(a);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sum(longint s);
		if (s > SMP_MAX) s = SMP_MAX;
		if (s < SMP_MIN) s = SMP_MIN;
		return s[SAMPLE_BITS-1:0];
	endfunction

	task automatic predict_looper(input item_t it, output result_t r);
		int unsigned tgt, act, rp, p;
		logic [STEP_W-1:0] code;
		r.left_out = it.left_in;
		r.right_out = it.right_in;
		r.active_cutoff = it.knob_cutoff;
		r.active_delay = it.knob_delay;
		r.active_feedback = it.knob_feedback;
		if (it.mode == MODE_EMPTY) begin
			wr_pos = 0;
			rd_pos = 0;
			loop_len = 0;
		end else if (it.mode == MODE_DUB && loop_len == 0) begin
			tgt = target_len;
			if (tgt < 1) tgt = 1;
			if (tgt > MAX_LOOP_DEF) tgt = MAX_LOOP_DEF;
			if (wr_pos < MAX_LOOP_DEF) begin
				loop_l[wr_pos] = it.left_in;
				loop_r[wr_pos] = it.right_in;
				cut_lane[wr_pos] = it.knob_cutoff;
				del_lane[wr_pos] = it.knob_delay;
				fb_lane[wr_pos] = it.knob_feedback;
				step_lane[wr_pos] = it.knob_step;
			end
			wr_pos = (wr_pos + 1) & POS_MASK;
			if (wr_pos >= tgt) begin
				loop_len = tgt;
				rd_pos = 0;
				wr_pos = 0;
			end
		end else if ((it.mode == MODE_PLAY || it.mode == MODE_DUB) && loop_len > 0) begin
			code = rec_step ? it.knob_step : step_lane[rd_pos % loop_len];
			act = section_len(loop_len, code);
			rp = rd_pos % act;
			p = reverse_on ? (act - 1 - rp) : rp;
			if (p >= MAX_LOOP_DEF) p = 0;
			if (it.mode == MODE_DUB) begin
				if (rec_cut) cut_lane[p] = it.knob_cutoff;
				if (rec_del) del_lane[p] = it.knob_delay;
				if (rec_fb) fb_lane[p] = it.knob_feedback;
				if (rec_step) step_lane[p] = it.knob_step;
			end
			r.active_cutoff = rec_cut ? it.knob_cutoff : cut_lane[p];
			r.active_delay = rec_del ? it.knob_delay : del_lane[p];
			r.active_feedback = rec_fb ? it.knob_feedback : fb_lane[p];
			r.left_out = loop_l[p];
			r.right_out = loop_r[p];
			if (it.mode == MODE_DUB) begin
				loop_l[p] = sat_sum(longint'($signed(loop_l[p])) + longint'($signed(it.left_in)));
				loop_r[p] = sat_sum(longint'($signed(loop_r[p])) + longint'($signed(it.right_in)));
				r.left_out = loop_l[p];
				r.right_out = loop_r[p];
			end
			rd_pos = (rp + 1) & POS_MASK;
		end
	endtask

	// one input transfer; prediction is made when it is accepted
	task automatic send_item(input item_t it);
		result_t r;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			item_valid = 0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item = it;
		item_valid = 1;
		do @(posedge clk); while (!item_ready);
		predict_looper(it, r);
		expected_q = {expected_q, r};
		@(negedge clk);
	endtask

	// all results back, then the block's longest item time
	task automatic settle();
		item_valid = 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		cfg_we = 1;
		cfg_idx = idx;
		cfg_wdata = val[TGT_W-1:0];
		@(negedge clk);
		cfg_we = 0;
		case (idx)
			CFG_REVERSE: reverse_on = val[0];
			CFG_REC_CUT: rec_cut = val[0];
			CFG_REC_DEL: rec_del = val[0];
			CFG_REC_FB:  rec_fb = val[0];
			CFG_REC_STP: rec_step = val[0];
			CFG_TARGET:  target_len = val & POS_MASK;
			default: ;
		endcase
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		int unsigned k;
		k = $urandom_range(9);
		if (k == 0) return SAMPLE_BITS'(SMP_MAX);
		if (k == 1) return SAMPLE_BITS'(SMP_MIN);
		return SAMPLE_BITS'($urandom());
	endfunction

	function automatic item_t make_item(logic [1:0] m);
		item_t it;
		it.mode = m;
		it.left_in = pick_sample();
		it.right_in = pick_sample();
		it.knob_cutoff = CUT_W'($urandom());
		it.knob_delay = DEL_W'($urandom());
		it.knob_feedback = FB_W'($urandom());
		it.knob_step = STEP_W'($urandom());
		return it;
	endfunction

	function automatic item_t sample_item(logic [1:0] m, int l, int r, logic [STEP_W-1:0] st);
		item_t it;
		it = make_item(m);
		it.left_in = SAMPLE_BITS'(l);
		it.right_in = SAMPLE_BITS'(r);
		it.knob_step = st;
		return it;
	endfunction

	task automatic report_mismatch(input string field, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result transfer", 1, 0);
			end else begin
				want = expected_q.pop_front();
				if (result.left_out !== want.left_out)
					report_mismatch("left_out", $signed(result.left_out), $signed(want.left_out));
				if (result.right_out !== want.right_out)
					report_mismatch("right_out", $signed(result.right_out), $signed(want.right_out));
				if (result.active_cutoff !== want.active_cutoff)
					report_mismatch("active_cutoff", result.active_cutoff, want.active_cutoff);
				if (result.active_delay !== want.active_delay)
					report_mismatch("active_delay", result.active_delay, want.active_delay);
				if (result.active_feedback !== want.active_feedback)
					report_mismatch("active_feedback", result.active_feedback, want.active_feedback);
			end
		end
	end

	// receiver side: random stalls, or a long hold-off on request
	initial begin
		result_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_ready = 0;
				repeat (300) @(negedge clk);
				hold_req = 0;
			end
			result_ready = !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
		end
	end

	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready) || cfg_we)
				idle = 0;
			else
				idle++;
			if (idle >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic test_directed();
		// play with nothing recorded, unused mode, empty
		send_item(make_item(MODE_PLAY));
		send_item(make_item(MODE_UNUSED));
		send_item(make_item(MODE_EMPTY));
		settle();
		write_reg(CFG_TARGET, 4);
		write_reg(CFG_REC_STP, 0);
		send_item(sample_item(MODE_DUB, SMP_MAX, SMP_MIN, 3'd0));
		send_item(sample_item(MODE_DUB, SMP_MIN, SMP_MAX, 3'd7));
		send_item(sample_item(MODE_DUB, 0, -1, 3'd2));
		send_item(sample_item(MODE_DUB, 1, 0, 3'd3));
		send_item(make_item(MODE_PLAY));
		// overdub of opposite extremes onto recorded extremes: the sums cancel, no saturation
		send_item(sample_item(MODE_DUB, SMP_MAX, SMP_MIN, 3'd1));
		send_item(sample_item(MODE_DUB, SMP_MIN, SMP_MAX, 3'd5));
		settle();
		write_reg(CFG_REVERSE, 1);
		write_reg(CFG_REC_CUT, 1);
		write_reg(CFG_REC_STP, 1);
		send_item(sample_item(MODE_DUB, 5, 5, 3'd6));
		send_item(make_item(MODE_PLAY));
		settle();
		// target of zero acts as one
		write_reg(CFG_TARGET, 0);
		send_item(make_item(MODE_EMPTY));
		send_item(make_item(MODE_DUB));
		send_item(make_item(MODE_PLAY));
		settle();
		// target above the store depth, then the largest in range: never completed
		write_reg(CFG_TARGET, 32'h7FFFFF);
		send_item(make_item(MODE_EMPTY));
		send_item(make_item(MODE_DUB));
		settle();
		write_reg(CFG_TARGET, MAX_LOOP_DEF);
		send_item(make_item(MODE_DUB));
		send_item(make_item(MODE_EMPTY));
		settle();
		// target lowered during the first pass
		write_reg(CFG_TARGET, 20);
		repeat (3) send_item(make_item(MODE_DUB));
		settle();
		write_reg(CFG_TARGET, 2);
		send_item(make_item(MODE_DUB));
		send_item(make_item(MODE_PLAY));
		settle();
	endtask

	task automatic random_config();
		int unsigned t;
		write_reg(CFG_REVERSE, $urandom_range(1));
		write_reg(CFG_REC_CUT, $urandom_range(1));
		write_reg(CFG_REC_DEL, $urandom_range(1));
		write_reg(CFG_REC_FB, $urandom_range(1));
		write_reg(CFG_REC_STP, $urandom_range(1));
		case ($urandom_range(9))
			0: t = 1;
			1: t = $urandom_range(100, 300);
			default: t = $urandom_range(2, 64);
		endcase
		write_reg(CFG_TARGET, t);
	endtask

	// a fresh recording pass followed by play and overdub with some noise
	task automatic loop_session(input int n_play);
		int unsigned k;
		random_config();
		send_item(make_item(MODE_EMPTY));
		repeat (target_len) send_item(make_item(MODE_DUB));
		for (int i = 0; i < n_play; i++) begin
			if (i == n_play / 2) begin
				settle();
				write_reg(CFG_REVERSE, $urandom_range(1));
				write_reg(CFG_REC_STP, $urandom_range(1));
				write_reg(CFG_REC_CUT, $urandom_range(1));
			end
			k = $urandom_range(99);
			if (k < 3) send_item(make_item(MODE_EMPTY));
			else if (k < 8) send_item(make_item(MODE_UNUSED));
			else if (k < 50) send_item(make_item(MODE_PLAY));
			else send_item(make_item(MODE_DUB));
		end
		settle();
	endtask

	task automatic test_random(input int n_items);
		int sent;
		sent = 0;
		while (sent < n_items) begin
			loop_session(40);
			sent += 41 + int'(target_len);
		end
	endtask

	task automatic test_backpressure();
		settle();
		write_reg(CFG_TARGET, 8);
		send_item(make_item(MODE_EMPTY));
		repeat (8) send_item(make_item(MODE_DUB));
		hold_req = 1;
		repeat (20) send_item(make_item($urandom_range(1) ? MODE_PLAY : MODE_DUB));
		settle();
	endtask

	initial begin
		errors = 0;
		hold_req = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		wr_pos = 0;
		rd_pos = 0;
		loop_len = 0;
		reverse_on = 0;
		rec_cut = 0;
		rec_del = 0;
		rec_fb = 0;
		rec_step = 0;
		target_len = TGT_RESET;
		@(posedge arst_n);
		@(negedge clk);
		test_directed();
		send_idle_pct = 6;
		recv_idle_pct = 60;
		test_random(110);
		send_idle_pct = 60;
		recv_idle_pct = 6;
		test_random(110);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(110);
		test_backpressure();
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
